/* src/sorted_set_merge_ops_assert.svh */
// Assertion macros for the sorted set merge RTL.
`ifndef SORTED_SET_MERGE_OPS_ASSERT_SVH
`define SORTED_SET_MERGE_OPS_ASSERT_SVH

// Same-cycle implication, checked on clk and suspended while reset is held.
`define SSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and suspended while reset is held.
`define SSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ssm_pkg.sv */
// Shared constants and types for the sorted set merge block.
package ssm_pkg;

  // Field widths.
  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;

  // Default store capacity.
  localparam int SET_DEPTH_DEF = 32;

  // Function codes of an input item.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND_A = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_APPEND_B = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ISECT    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_UNION    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DIFF     = 3'd5;

  // Request from the front end to start a merge run.
  typedef struct packed {
    logic              start;
    logic [FUNC_W-1:0] op;
  } ssm_run_req_t;

endpackage

/* src/sorted_set_merge_ops.sv */
// Sorted set merge block: two value stores and the intersection, union and difference engine.
//
// Clear and append items are taken back to back. A set operation is accepted,
// then runs its merge steps one after another, then delivers the
// final item. Every merge step moves at least one of the two pointers, so any
// of the three operations needs count_a + count_b steps at most (twice
// SET_DEPTH at the full capacity); intersection stops as soon as either store
// is used up and difference as soon as A is. Each merge step reads one entry
// of each store through its synchronous read port, so the merge loop moves at
// one step per cycle unless a stalled result channel holds it. No new item is
// taken while a run is in progress. An append to a full store is dropped; an
// empty answer comes out as one item flagged empty.
module sorted_set_merge_ops
  import ssm_pkg::*;
#(
  parameter int SET_DEPTH = SET_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic signed [DATA_W-1:0] in_element_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic                     out_last_of_run,
  output logic                     out_empty_set
);

  localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNT_W = $clog2(SET_DEPTH + 1);

  logic [CNT_W-1:0]  cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0]  cnt_b_r, cnt_b_nxt;
  logic              accept, busy;
  logic              wr_a, wr_b;
  logic [IDX_W-1:0]  rd_addr_a, rd_addr_b;
  logic [DATA_W-1:0] rd_a, rd_b;
  ssm_run_req_t      req;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  // Decode the accepted item.
  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    req.start = accept && (in_func inside {FUNC_ISECT, FUNC_UNION, FUNC_DIFF});
    req.op    = in_func;
    if (accept) begin
      case (in_func)
        FUNC_CLEAR: begin
          cnt_a_nxt = '0;
          cnt_b_nxt = '0;
        end
        FUNC_APPEND_A: begin
          if (cnt_a_r < CNT_W'(SET_DEPTH)) begin
            wr_a      = 1'b1;
            cnt_a_nxt = cnt_a_r + CNT_W'(1);
          end
        end
        FUNC_APPEND_B: begin
          if (cnt_b_r < CNT_W'(SET_DEPTH)) begin
            wr_b      = 1'b1;
            cnt_b_nxt = cnt_b_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Fill counts of the two stores.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
    end else begin
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
    end
  end

  // Store A.
  ssm_store #(
    .DEPTH (SET_DEPTH)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (cnt_a_r[IDX_W-1:0]),
    .wr_data (in_element_value),
    .rd_addr (rd_addr_a),
    .rd_data (rd_a)
  );

  // Store B.
  ssm_store #(
    .DEPTH (SET_DEPTH)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (cnt_b_r[IDX_W-1:0]),
    .wr_data (in_element_value),
    .rd_addr (rd_addr_b),
    .rd_data (rd_b)
  );

  // Merge engine and result register.
  ssm_merge #(
    .SET_DEPTH (SET_DEPTH)
  ) u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .req              (req),
    .cnt_a            (cnt_a_r),
    .cnt_b            (cnt_b_r),
    .rd_a             (rd_a),
    .rd_b             (rd_b),
    .rd_addr_a        (rd_addr_a),
    .rd_addr_b        (rd_addr_b),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_last_of_run  (out_last_of_run),
    .out_empty_set    (out_empty_set)
  );

endmodule

/* src/ssm_store.sv */
// One set store: single write port, one synchronous read port.
module ssm_store
  import ssm_pkg::*;
#(
  parameter int DEPTH = SET_DEPTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/ssm_merge.sv */
// Two-pointer merge sequencer with a one-deep hold stage and the output register.
module ssm_merge
  import ssm_pkg::*;
#(
  parameter int SET_DEPTH = SET_DEPTH_DEF,
  localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1,
  localparam int CNT_W = $clog2(SET_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ssm_run_req_t             req,
  input  logic [CNT_W-1:0]         cnt_a,
  input  logic [CNT_W-1:0]         cnt_b,
  input  logic [DATA_W-1:0]        rd_a,
  input  logic [DATA_W-1:0]        rd_b,
  output logic [IDX_W-1:0]         rd_addr_a,
  output logic [IDX_W-1:0]         rd_addr_b,
  output logic                     busy,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic                     out_last_of_run,
  output logic                     out_empty_set
);

  `include "sorted_set_merge_ops_assert.svh"

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // Decision of one merge step.
  typedef struct packed {
    logic              done;
    logic              emit;
    logic              inc_a;
    logic              inc_b;
    logic [DATA_W-1:0] val;
  } step_t;

  logic              state_r, state_nxt;
  logic [FUNC_W-1:0] op_r, op_nxt;
  logic [CNT_W-1:0]  ptr_a_r, ptr_a_nxt;
  logic [CNT_W-1:0]  ptr_b_r, ptr_b_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [DATA_W-1:0] pend_val_r, pend_val_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_val_r, out_val_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_empty_r, out_empty_nxt;

  logic  avail_a, avail_b, a_lt_b, a_eq_b, can_push;
  step_t step;

  assign avail_a  = (ptr_a_r < cnt_a);
  assign avail_b  = (ptr_b_r < cnt_b);
  assign a_lt_b   = ($signed(rd_a) < $signed(rd_b));
  assign a_eq_b   = (rd_a == rd_b);
  assign can_push = !out_valid_r || !out_stall;

  // What the current pair of store heads asks for under the running operation.
  always_comb begin
    step = '0;
    case (op_r)
      FUNC_ISECT: begin
        if (!(avail_a && avail_b)) begin
          step.done = 1'b1;
        end else if (a_lt_b) begin
          step.inc_a = 1'b1;
        end else if (!a_eq_b) begin
          step.inc_b = 1'b1;
        end else begin
          step.emit  = 1'b1;
          step.val   = rd_a;
          step.inc_a = 1'b1;
          step.inc_b = 1'b1;
        end
      end
      FUNC_UNION: begin
        if (!avail_a && !avail_b) begin
          step.done = 1'b1;
        end else if (!avail_b || (avail_a && a_lt_b)) begin
          step.emit  = 1'b1;
          step.val   = rd_a;
          step.inc_a = 1'b1;
        end else if (!avail_a || !a_eq_b) begin
          // A is used up, or B holds the smaller head.
          step.emit  = 1'b1;
          step.val   = rd_b;
          step.inc_b = 1'b1;
        end else begin
          // Equal heads: the copy in A goes out on a later step.
          step.inc_b = 1'b1;
        end
      end
      default: begin
        if (!avail_a) begin
          step.done = 1'b1;
        end else if (!avail_b || a_lt_b) begin
          step.emit  = 1'b1;
          step.val   = rd_a;
          step.inc_a = 1'b1;
        end else if (!a_eq_b) begin
          step.inc_b = 1'b1;
        end else begin
          step.inc_a = 1'b1;
          step.inc_b = 1'b1;
        end
      end
    endcase
  end

  // Sequencer. A result is held back one step so that the final one can be marked.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ptr_a_nxt     = ptr_a_r;
    ptr_b_nxt     = ptr_b_r;
    pend_v_nxt    = pend_v_r;
    pend_val_nxt  = pend_val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    case (state_r)
      ST_IDLE: begin
        ptr_a_nxt = '0;
        ptr_b_nxt = '0;
        if (req.start) begin
          state_nxt = ST_RUN;
          op_nxt    = req.op;
        end
      end
      ST_RUN: begin
        if (step.done) begin
          if (can_push) begin
            out_valid_nxt = 1'b1;
            out_val_nxt   = pend_v_r ? pend_val_r : '0;
            out_last_nxt  = 1'b1;
            out_empty_nxt = !pend_v_r;
            pend_v_nxt    = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end else if (!(step.emit && pend_v_r && !can_push)) begin
          if (step.inc_a) begin
            ptr_a_nxt = ptr_a_r + CNT_W'(1);
          end
          if (step.inc_b) begin
            ptr_b_nxt = ptr_b_r + CNT_W'(1);
          end
          if (step.emit) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_val_nxt   = pend_val_r;
              out_last_nxt  = 1'b0;
              out_empty_nxt = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_val_nxt = step.val;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and pointer registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    ptr_a_r     <= ptr_a_nxt;
    ptr_b_r     <= ptr_b_nxt;
    pend_val_r  <= pend_val_nxt;
    out_val_r   <= out_val_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  // Reads follow the next pointers so the heads are ready in the following cycle.
  assign rd_addr_a = (ptr_a_nxt < CNT_W'(SET_DEPTH)) ? ptr_a_nxt[IDX_W-1:0] : '0;
  assign rd_addr_b = (ptr_b_nxt < CNT_W'(SET_DEPTH)) ? ptr_b_nxt[IDX_W-1:0] : '0;

  assign busy             = (state_r == ST_RUN);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_last_of_run  = out_last_r;
  assign out_empty_set    = out_empty_r;

  `SSM_ASSERT_IMP(a_ptr_a_bound, state_r == ST_RUN, ptr_a_r <= cnt_a, "pointer A ran past count A")
  `SSM_ASSERT_IMP(a_ptr_b_bound, state_r == ST_RUN, ptr_b_r <= cnt_b, "pointer B ran past count B")
  `SSM_ASSERT_IMP(a_idle_no_pend, state_r == ST_IDLE, !pend_v_r, "held result left after run")
  `SSM_ASSERT_IMP(a_run_closes, state_r == ST_RUN ##1 state_r == ST_IDLE, out_valid_r && out_last_r, "run ended without a marked final item")
  `SSM_ASSERT_NXT(a_start_runs, state_r == ST_IDLE && req.start, state_r == ST_RUN, "run request not taken")

endmodule
